FILE: rtl/core/amh_pkg.sv
// Shared field widths, operation codes and status codes of the activity max-heap.
package amh_pkg;

    localparam int ID_W    = 8;
    localparam int SCORE_W = 32;
    localparam int OP_W    = 3;
    localparam int STAT_W  = 2;

    typedef logic [OP_W-1:0]   t_op;
    typedef logic [STAT_W-1:0] t_status;

    localparam t_op OP_INSERT   = 3'd0;
    localparam t_op OP_INCREASE = 3'd1;
    localparam t_op OP_REMOVE   = 3'd2;
    localparam t_op OP_DECAY    = 3'd3;
    localparam t_op OP_CLEAR    = 3'd4;

    localparam t_status ST_OK     = 2'd0;
    localparam t_status ST_EMPTY  = 2'd1;
    localparam t_status ST_NONTOP = 2'd2;
    localparam t_status ST_BAD_ID = 2'd3;

endpackage

FILE: rtl/core/amh_ram.sv
// Simple dual-port synchronous memory with registered read.
module amh_ram #(
    parameter int W     = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [W-1:0]             i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [W-1:0]             o_rdata
);

    logic [W-1:0] mem [DEPTH];

    // write one entry, register one read (old data on collision)
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end

endmodule

FILE: rtl/core/activity_max_heap_unit.sv
// Top level of the activity max-heap: sequencer over the heap and record memories.
//
// Usage: drive i_op, i_elem and i_increment and raise start while busy is low;
// the command beat is taken at that edge and busy goes high; a config write in
// that cycle wins and the command is dropped. Exactly one result beat follows,
// marked by o_strobe for one cycle, with the removed id, the top id and score,
// the overflow flag, the heap count and the status.
// Every command ends with a read of the top slot, then of its record, before the
// strobe; a bad id, an empty remove or an unused op code goes straight there. A
// sift-up reads the parent slot, then its score, then writes, per level climbed;
// a sift-down reads the child slots and scores, then writes, per level sunk. A
// decay of an absent id reads its record, multiplies and writes the score back.
// A decay of the top id runs a remove and an insert back to back. A clear of all
// scores is a read-modify-write sweep of the record memory. One command is in
// flight at a time; the next one is taken from the strobe cycle on. Each memory
// has a single read port: every heap level needs a slot read, then a score read.
// Configuration: i_cfg_we with i_cfg_wdata writes num_elems while idle and
// rebuilds the heap; busy stays high for that sweep. Reset sets num_elems to
// 255 and runs the same sweep before the first command is taken. The receiver
// cannot stall; results are never held back.
module activity_max_heap_unit
    import amh_pkg::*;
#(
    parameter int MAX_ELEMS       = 255,
    parameter int SCORE_FRAC_BITS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [ID_W-1:0]     i_cfg_wdata,
    input  logic                start,
    output logic                busy,
    input  logic [OP_W-1:0]     i_op,
    input  logic [ID_W-1:0]     i_elem,
    input  logic [SCORE_W-1:0]  i_increment,
    output logic                o_strobe,
    output logic [ID_W-1:0]     o_removed_elem,
    output logic [ID_W-1:0]     o_top_elem,
    output logic [SCORE_W-1:0]  o_top_score,
    output logic                o_overflow,
    output logic [ID_W-1:0]     o_count,
    output logic [STAT_W-1:0]   o_status
);

    localparam int NMAX  = (MAX_ELEMS < 255) ? MAX_ELEMS : 255;
    localparam int PW    = $clog2(NMAX + 1);
    localparam int CW    = $clog2(NMAX + 2);
    localparam int RW    = PW + SCORE_W;
    localparam int F     = SCORE_FRAC_BITS;
    localparam int PRW   = SCORE_W + F;
    localparam logic [SCORE_W-1:0] SCORE_ONE = (F >= 32) ? 32'hFFFF_FFFF
                                                         : 32'(64'd1 << F);
    localparam logic [F-1:0] DECAY_K = F'((64'd9 << F) / 64'd10);

    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_INIT  = 5'd1;
    localparam logic [4:0] S_CLR   = 5'd2;
    localparam logic [4:0] S_REC   = 5'd3;
    localparam logic [4:0] S_MUL   = 5'd4;
    localparam logic [4:0] S_DECW  = 5'd5;
    localparam logic [4:0] S_RMB   = 5'd6;
    localparam logic [4:0] S_RMC   = 5'd7;
    localparam logic [4:0] S_RMD   = 5'd8;
    localparam logic [4:0] S_DN0   = 5'd9;
    localparam logic [4:0] S_DN1   = 5'd10;
    localparam logic [4:0] S_DN2   = 5'd11;
    localparam logic [4:0] S_DN3   = 5'd12;
    localparam logic [4:0] S_DN4   = 5'd13;
    localparam logic [4:0] S_RMEND = 5'd14;
    localparam logic [4:0] S_UP    = 5'd15;
    localparam logic [4:0] S_UP1   = 5'd16;
    localparam logic [4:0] S_UP2   = 5'd17;
    localparam logic [4:0] S_T0    = 5'd18;
    localparam logic [4:0] S_T1    = 5'd19;
    localparam logic [4:0] S_T2    = 5'd20;

    // control and datapath registers
    logic [4:0]         r_state, n_state;
    logic [ID_W-1:0]    r_num, n_num;
    logic [PW-1:0]      r_count, n_count;
    logic [CW-1:0]      r_cnt, n_cnt;
    t_op                r_op, n_op;
    logic [PW-1:0]      r_elem, n_elem;
    logic [SCORE_W-1:0] r_inc, n_inc;
    logic [PW-1:0]      r_id, n_id;
    logic [SCORE_W-1:0] r_sc, n_sc;
    logic [PW-1:0]      r_pos, n_pos;
    logic [PW:0]        r_child, n_child;
    logic [PW-1:0]      r_cid, n_cid;
    logic [SCORE_W-1:0] r_csc, n_csc;
    logic [PW-1:0]      r_rid, n_rid;
    logic [SCORE_W-1:0] r_dsc, n_dsc;
    logic [PRW-1:0]     r_prod, n_prod;
    logic               r_reins, n_reins;
    logic [PW-1:0]      r_rem, n_rem;
    logic               r_ovf, n_ovf;
    t_status            r_status, n_status;
    logic               r_strobe, n_strobe;
    logic [ID_W-1:0]    r_o_rem, n_o_rem;
    logic [ID_W-1:0]    r_o_top, n_o_top;
    logic [SCORE_W-1:0] r_o_score, n_o_score;

    // memory ports
    logic           h_we, r_we;
    logic [PW-1:0]  h_waddr, h_raddr, h_wdata, h_rd;
    logic [PW-1:0]  r_waddr, r_raddr;
    logic [RW-1:0]  r_wdata, r_rd;

    logic [PW-1:0]      nn;
    logic               good;
    logic [PW-1:0]      rd_slot;
    logic [SCORE_W-1:0] rd_score;
    logic [SCORE_W:0]   sum;
    logic               init_in;

    // heap slots: position -> id
    amh_ram #(.W(PW), .DEPTH(NMAX + 1)) u_heap (
        .i_clk  (i_clk),
        .i_we   (h_we),
        .i_waddr(h_waddr),
        .i_wdata(h_wdata),
        .i_raddr(h_raddr),
        .o_rdata(h_rd)
    );

    // id records: {heap position, score}
    amh_ram #(.W(RW), .DEPTH(NMAX + 1)) u_rec (
        .i_clk  (i_clk),
        .i_we   (r_we),
        .i_waddr(r_waddr),
        .i_wdata(r_wdata),
        .i_raddr(r_raddr),
        .o_rdata(r_rd)
    );

    assign nn       = (r_num > ID_W'(NMAX)) ? PW'(NMAX) : PW'(r_num);
    assign good     = (i_elem != '0) && ({1'b0, i_elem} <= 9'(nn));
    assign rd_slot  = r_rd[RW-1:SCORE_W];
    assign rd_score = r_rd[SCORE_W-1:0];
    assign sum      = {1'b0, rd_score} + {1'b0, r_inc};
    assign init_in  = (r_cnt != '0) && (r_cnt <= CW'(nn));

    // sequence one command through the memories
    always_comb begin
        n_state = r_state;   n_num = r_num;     n_count = r_count; n_cnt = r_cnt;
        n_op = r_op;         n_elem = r_elem;   n_inc = r_inc;     n_id = r_id;
        n_sc = r_sc;         n_pos = r_pos;     n_child = r_child; n_cid = r_cid;
        n_csc = r_csc;       n_rid = r_rid;     n_dsc = r_dsc;     n_prod = r_prod;
        n_reins = r_reins;   n_rem = r_rem;     n_ovf = r_ovf;     n_status = r_status;
        n_strobe = 1'b0;     n_o_rem = r_o_rem; n_o_top = r_o_top; n_o_score = r_o_score;
        h_we = 1'b0; h_waddr = '0; h_wdata = '0; h_raddr = '0;
        r_we = 1'b0; r_waddr = '0; r_wdata = '0; r_raddr = '0;
        case (r_state)
            S_IDLE: begin
                h_raddr = PW'(1);
                r_raddr = PW'(i_elem);
                if (i_cfg_we) begin
                    n_num   = i_cfg_wdata;
                    n_cnt   = '0;
                    n_state = S_INIT;
                end else if (start) begin
                    n_op     = i_op;
                    n_elem   = PW'(i_elem);
                    n_inc    = i_increment;
                    n_ovf    = 1'b0;
                    n_status = ST_OK;
                    n_reins  = 1'b0;
                    case (i_op)
                        OP_INSERT, OP_INCREASE, OP_DECAY: begin
                            if (good) begin
                                n_state = S_REC;
                            end else begin
                                n_status = ST_BAD_ID;
                                n_state  = S_T0;
                            end
                        end
                        OP_REMOVE: begin
                            if (r_count == '0) begin
                                n_status = ST_EMPTY;
                                n_state  = S_T0;
                            end else begin
                                n_state = S_RMB;
                            end
                        end
                        OP_CLEAR: begin
                            n_cnt   = CW'(1);
                            n_state = S_CLR;
                        end
                        default: n_state = S_T0;
                    endcase
                end
            end
            S_INIT: begin
                // rebuild: identity order, every score one
                h_we    = 1'b1;
                h_waddr = PW'(r_cnt);
                h_wdata = init_in ? PW'(r_cnt) : '0;
                r_we    = 1'b1;
                r_waddr = PW'(r_cnt);
                r_wdata = init_in ? {PW'(r_cnt), SCORE_ONE} : '0;
                if (r_cnt == CW'(NMAX)) begin
                    n_count = nn;
                    n_state = S_IDLE;
                end else begin
                    n_cnt = r_cnt + CW'(1);
                end
            end
            S_CLR: begin
                // read one record ahead, zero the score of the previous one
                r_raddr = PW'(r_cnt);
                if (r_cnt >= CW'(2)) begin
                    r_we    = 1'b1;
                    r_waddr = PW'(r_cnt - CW'(1));
                    r_wdata = {rd_slot, {SCORE_W{1'b0}}};
                end
                if (r_cnt == CW'(nn) + CW'(1)) begin
                    n_state = S_T0;
                end else begin
                    n_cnt = r_cnt + CW'(1);
                end
            end
            S_REC: begin
                case (r_op)
                    OP_INSERT: begin
                        if (rd_slot != '0) begin
                            n_state = S_T0;
                        end else begin
                            n_id    = r_elem;
                            n_sc    = rd_score;
                            n_pos   = r_count + PW'(1);
                            n_count = r_count + PW'(1);
                            n_state = S_UP;
                        end
                    end
                    OP_INCREASE: begin
                        if (sum[SCORE_W]) begin
                            n_ovf   = 1'b1;
                            n_state = S_T0;
                        end else begin
                            r_we    = 1'b1;
                            r_waddr = r_elem;
                            r_wdata = {rd_slot, sum[SCORE_W-1:0]};
                            n_id    = r_elem;
                            n_sc    = sum[SCORE_W-1:0];
                            n_pos   = rd_slot;
                            n_state = (rd_slot != '0) ? S_UP : S_T0;
                        end
                    end
                    default: begin
                        if (rd_slot == '0 || rd_slot == PW'(1)) begin
                            n_sc    = rd_score;
                            n_pos   = rd_slot;
                            n_state = S_MUL;
                        end else begin
                            n_status = ST_NONTOP;
                            n_state  = S_T0;
                        end
                    end
                endcase
            end
            S_MUL: begin
                n_prod  = PRW'(r_sc) * PRW'(DECAY_K);
                n_state = S_DECW;
            end
            S_DECW: begin
                if (r_pos == '0) begin
                    r_we    = 1'b1;
                    r_waddr = r_elem;
                    r_wdata = {{PW{1'b0}}, r_prod[F +: SCORE_W]};
                    n_state = S_T0;
                end else begin
                    n_dsc   = r_prod[F +: SCORE_W];
                    n_reins = 1'b1;
                    h_raddr = PW'(1);
                    n_state = S_RMB;
                end
            end
            S_RMB: begin
                n_rem   = h_rd;
                r_raddr = h_rd;
                h_raddr = r_count;
                n_state = S_RMC;
            end
            S_RMC: begin
                // mark the old top absent, take the last slot's id
                r_we    = 1'b1;
                r_waddr = r_rem;
                r_wdata = {{PW{1'b0}}, rd_score};
                n_id    = h_rd;
                n_count = r_count - PW'(1);
                r_raddr = h_rd;
                n_state = S_RMD;
            end
            S_RMD: begin
                n_sc    = rd_score;
                n_pos   = PW'(1);
                n_child = (PW+1)'(2);
                n_state = (r_count == '0) ? S_RMEND : S_DN0;
            end
            S_DN0: begin
                if (r_child > {1'b0, r_count}) begin
                    h_we    = 1'b1;
                    h_waddr = r_pos;
                    h_wdata = r_id;
                    r_we    = 1'b1;
                    r_waddr = r_id;
                    r_wdata = {r_pos, r_sc};
                    n_state = S_RMEND;
                end else begin
                    h_raddr = PW'(r_child);
                    n_state = S_DN1;
                end
            end
            S_DN1: begin
                n_cid   = h_rd;
                r_raddr = h_rd;
                h_raddr = PW'(r_child + (PW+1)'(1));
                n_state = S_DN2;
            end
            S_DN2: begin
                n_csc = rd_score;
                if (r_child < {1'b0, r_count}) begin
                    n_rid   = h_rd;
                    r_raddr = h_rd;
                    n_state = S_DN3;
                end else begin
                    n_state = S_DN4;
                end
            end
            S_DN3: begin
                // right child wins only when strictly greater
                if (rd_score > r_csc) begin
                    n_cid   = r_rid;
                    n_csc   = rd_score;
                    n_child = r_child + (PW+1)'(1);
                end
                n_state = S_DN4;
            end
            S_DN4: begin
                h_we = 1'b1;
                r_we = 1'b1;
                h_waddr = r_pos;
                if (r_sc > r_csc) begin
                    h_wdata = r_id;
                    r_waddr = r_id;
                    r_wdata = {r_pos, r_sc};
                    n_state = S_RMEND;
                end else begin
                    h_wdata = r_cid;
                    r_waddr = r_cid;
                    r_wdata = {r_pos, r_csc};
                    n_pos   = PW'(r_child);
                    n_child = {r_child[PW-1:0], 1'b0};
                    n_state = S_DN0;
                end
            end
            S_RMEND: begin
                if (r_reins) begin
                    n_id    = r_elem;
                    n_sc    = r_dsc;
                    n_pos   = r_count + PW'(1);
                    n_count = r_count + PW'(1);
                    n_state = S_UP;
                end else begin
                    n_state = S_T0;
                end
            end
            S_UP: begin
                if (r_pos == PW'(1)) begin
                    h_we    = 1'b1;
                    h_waddr = r_pos;
                    h_wdata = r_id;
                    r_we    = 1'b1;
                    r_waddr = r_id;
                    r_wdata = {r_pos, r_sc};
                    n_state = S_T0;
                end else begin
                    h_raddr = r_pos >> 1;
                    n_state = S_UP1;
                end
            end
            S_UP1: begin
                n_cid   = h_rd;
                r_raddr = h_rd;
                n_state = S_UP2;
            end
            S_UP2: begin
                // parent stays only when strictly greater
                h_we    = 1'b1;
                r_we    = 1'b1;
                h_waddr = r_pos;
                if (rd_score > r_sc) begin
                    h_wdata = r_id;
                    r_waddr = r_id;
                    r_wdata = {r_pos, r_sc};
                    n_state = S_T0;
                end else begin
                    h_wdata = r_cid;
                    r_waddr = r_cid;
                    r_wdata = {r_pos, rd_score};
                    n_pos   = r_pos >> 1;
                    n_state = S_UP;
                end
            end
            S_T0: begin
                h_raddr = PW'(1);
                n_state = S_T1;
            end
            S_T1: begin
                n_cid   = h_rd;
                r_raddr = h_rd;
                n_state = S_T2;
            end
            S_T2: begin
                // emit the result beat
                n_strobe  = 1'b1;
                n_o_rem   = (r_op == OP_REMOVE && r_status == ST_OK) ? ID_W'(r_rem) : '0;
                n_o_top   = (r_count != '0) ? ID_W'(r_cid) : '0;
                n_o_score = (r_count != '0) ? rd_score : '0;
                n_state   = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_INIT;
            r_num    <= ID_W'(255);
            r_count  <= '0;
            r_cnt    <= '0;
            r_strobe <= 1'b0;
            r_reins  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_num    <= n_num;
            r_count  <= n_count;
            r_cnt    <= n_cnt;
            r_strobe <= n_strobe;
            r_reins  <= n_reins;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_op <= n_op;       r_elem <= n_elem;   r_inc <= n_inc;     r_id <= n_id;
        r_sc <= n_sc;       r_pos <= n_pos;     r_child <= n_child; r_cid <= n_cid;
        r_csc <= n_csc;     r_rid <= n_rid;     r_dsc <= n_dsc;     r_prod <= n_prod;
        r_rem <= n_rem;     r_ovf <= n_ovf;     r_status <= n_status;
        r_o_rem <= n_o_rem; r_o_top <= n_o_top; r_o_score <= n_o_score;
    end

    assign busy           = (r_state != S_IDLE);
    assign o_strobe       = r_strobe;
    assign o_removed_elem = r_o_rem;
    assign o_top_elem     = r_o_top;
    assign o_top_score    = r_o_score;
    assign o_overflow     = r_ovf;
    assign o_count        = ID_W'(r_count);
    assign o_status       = r_status;

    a_strobe_after_t2: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(r_state) == S_T2)
        else $error("result beat without final top read");

    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !busy)
        else $error("result beat while still busy");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_INIT) |-> (r_count <= nn))
        else $error("heap count exceeds element count");

    a_empty_top: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_count == '0) |-> (o_top_elem == '0 && o_top_score == '0))
        else $error("empty heap reports a top");

endmodule

FILE: tb/activity_max_heap_unit_chk.sv
// Checker for the activity max-heap: mirrors the heap, predicts each result beat and compares.
`timescale 1ns / 100ps
module activity_max_heap_unit_chk
    import amh_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [ID_W-1:0]     i_cfg_wdata,
    input  logic                start,
    input  logic                busy,
    input  logic [OP_W-1:0]     i_op,
    input  logic [ID_W-1:0]     i_elem,
    input  logic [SCORE_W-1:0]  i_increment,
    input  logic                o_strobe,
    input  logic [ID_W-1:0]     o_removed_elem,
    input  logic [ID_W-1:0]     o_top_elem,
    input  logic [SCORE_W-1:0]  o_top_score,
    input  logic                o_overflow,
    input  logic [ID_W-1:0]     o_count,
    input  logic [STAT_W-1:0]   o_status,
    output int                  o_fail_cnt,
    output int                  o_pending
);

    localparam int FRAC = 16;
    localparam logic [SCORE_W-1:0] ONE = 32'h0001_0000;

    typedef struct packed {
        logic [ID_W-1:0]    removed;
        logic [ID_W-1:0]    top;
        logic [SCORE_W-1:0] score;
        logic               ovf;
        logic [ID_W-1:0]    cnt;
        t_status            stat;
    } t_beat;

    logic [ID_W-1:0]    slot_id [0:256];
    logic [SCORE_W-1:0] act     [0:255];
    logic [ID_W-1:0]    pos_of  [0:255];
    int                 n_ids;
    int                 heap_cnt;
    t_beat              expq [$];
    int                 fails;

    assign o_fail_cnt = fails;
    assign o_pending  = expq.size();

    // Restore identity heap with unit scores
    function automatic void heap_build(int n);
        for (int i = 0; i <= 256; i++) slot_id[i] = '0;
        for (int i = 0; i < 256; i++) begin
            act[i] = '0;
            pos_of[i] = '0;
        end
        for (int i = 1; i <= n; i++) begin
            slot_id[i] = ID_W'(i);
            act[i] = ONE;
            pos_of[i] = ID_W'(i);
        end
        n_ids = n;
        heap_cnt = n;
    endfunction

    function automatic void place(int id, int p);
        slot_id[p] = ID_W'(id);
        pos_of[id] = ID_W'(p);
    endfunction

    function automatic void climb(int p);
        int id;
        int par;
        id = slot_id[p];
        while (p > 1) begin
            par = slot_id[p / 2];
            if (act[par] > act[id]) break;
            place(par, p);
            p = p / 2;
        end
        place(id, p);
    endfunction

    function automatic void add_id(int id);
        if (pos_of[id] != 0) return;
        heap_cnt++;
        slot_id[heap_cnt] = ID_W'(id);
        climb(heap_cnt);
    endfunction

    function automatic int pop_top();
        int top;
        int p;
        int ch;
        int id;
        int cid;
        top = slot_id[1];
        p = 1;
        ch = 2;
        pos_of[top] = '0;
        id = slot_id[heap_cnt];
        slot_id[heap_cnt] = '0;
        heap_cnt--;
        while (ch <= heap_cnt) begin
            cid = slot_id[ch];
            if (ch < heap_cnt && act[slot_id[ch + 1]] > act[cid]) begin
                cid = slot_id[ch + 1];
                ch++;
            end
            if (act[id] > act[cid]) break;
            place(cid, p);
            p = ch;
            ch = p * 2;
        end
        if (heap_cnt != 0) place(id, p);
        return top;
    endfunction

    function automatic logic [SCORE_W-1:0] scaled_down(logic [SCORE_W-1:0] s);
        logic [63:0] fac;
        fac = (64'd9 << FRAC) / 64'd10;
        return SCORE_W'((64'(s) * fac) >> FRAC);
    endfunction

    // Apply one command beat and return the expected result beat
    function automatic t_beat heap_apply(t_op op, int e, logic [SCORE_W-1:0] inc);
        t_beat r;
        logic [32:0] sum;
        logic ok_id;
        r = '0;
        ok_id = (e >= 1 && e <= n_ids);
        if (op == OP_INSERT || op == OP_INCREASE || op == OP_DECAY) begin
            if (!ok_id) r.stat = ST_BAD_ID;
            else if (op == OP_INSERT) add_id(e);
            else if (op == OP_INCREASE) begin
                sum = {1'b0, act[e]} + {1'b0, inc};
                if (sum[32]) r.ovf = 1'b1;
                else begin
                    act[e] = sum[31:0];
                    if (pos_of[e] != 0) climb(pos_of[e]);
                end
            end else begin
                if (pos_of[e] == 0) act[e] = scaled_down(act[e]);
                else if (heap_cnt == 0 || slot_id[1] != e) r.stat = ST_NONTOP;
                else begin
                    void'(pop_top());
                    act[e] = scaled_down(act[e]);
                    add_id(e);
                end
            end
        end else if (op == OP_REMOVE) begin
            if (heap_cnt == 0) r.stat = ST_EMPTY;
            else r.removed = ID_W'(pop_top());
        end else if (op == OP_CLEAR) begin
            for (int i = 1; i <= n_ids; i++) act[i] = '0;
        end
        r.top   = heap_cnt != 0 ? slot_id[1] : '0;
        r.score = heap_cnt != 0 ? act[slot_id[1]] : '0;
        r.cnt   = ID_W'(heap_cnt);
        return r;
    endfunction

    // Track config, predict on accepted commands, compare result beats
    always @(posedge i_clk) begin
        t_beat got;
        t_beat want;
        if (!i_rst_n) begin
            heap_build(255);
            expq.delete();
            fails <= 0;
        end else begin
            if (i_cfg_we) heap_build(i_cfg_wdata > 255 ? 255 : int'(i_cfg_wdata));
            if (o_strobe) begin
                got = '{o_removed_elem, o_top_elem, o_top_score, o_overflow, o_count,
                        o_status};
                if (expq.size() == 0) begin
                    fails <= fails + 1;
                    if (fails < 10) $display("unexpected result beat %h", got);
                end else begin
                    want = expq.pop_front();
                    if (got !== want) begin
                        fails <= fails + 1;
                        if (fails < 10)
                            $display("mismatch: exp rem=%0d top=%0d sc=%h ovf=%0d cnt=%0d st=%0d | got rem=%0d top=%0d sc=%h ovf=%0d cnt=%0d st=%0d",
                                want.removed, want.top, want.score, want.ovf, want.cnt,
                                want.stat, got.removed, got.top, got.score, got.ovf,
                                got.cnt, got.stat);
                    end
                end
            end
            if (start && !busy) expq.push_back(heap_apply(t_op'(i_op), int'(i_elem), i_increment));
        end
    end

endmodule

FILE: tb/activity_max_heap_unit_tb.sv
// Testbench top for the activity max-heap: drives commands and config, reports the verdict.
`timescale 1ns / 100ps
module activity_max_heap_unit_tb
    import amh_pkg::*;
;

    localparam int WDOG_LIMIT = 20000;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic [ID_W-1:0]    i_cfg_wdata;
    logic               start;
    logic               busy;
    logic [OP_W-1:0]    i_op;
    logic [ID_W-1:0]    i_elem;
    logic [SCORE_W-1:0] i_increment;
    logic               o_strobe;
    logic [ID_W-1:0]    o_removed_elem;
    logic [ID_W-1:0]    o_top_elem;
    logic [SCORE_W-1:0] o_top_score;
    logic               o_overflow;
    logic [ID_W-1:0]    o_count;
    logic [STAT_W-1:0]  o_status;
    int                 fail_cnt;
    int                 pending;
    int                 idle_cycles;
    int                 cmd_cnt;
    int                 cur_n;

    activity_max_heap_unit dut (.*);
    activity_max_heap_unit_chk u_chk (.*, .o_fail_cnt(fail_cnt), .o_pending(pending));

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog: count cycles with no beat accepted either way
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_strobe || i_cfg_we) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Send one command beat after a random gap; start stays high with no gap
    task automatic send_cmd(t_op op, logic [ID_W-1:0] e, logic [SCORE_W-1:0] inc);
        int gap;
        gap = $urandom_range(0, 6);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_op <= op;
        i_elem <= e;
        i_increment <= inc;
        start <= 1'b1;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        cmd_cnt++;
    endtask

    // Drop start, wait for all results, let the block settle, then write num_elems
    task automatic set_elems(logic [ID_W-1:0] n);
        start <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        while (busy) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= n;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        cur_n = (n == 0) ? 0 : int'(n);
    endtask

    function automatic logic [ID_W-1:0] pick_id();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0) return ID_W'($urandom_range(0, 255));
        return ID_W'($urandom_range(1, cur_n > 0 ? cur_n : 1));
    endfunction

    function automatic logic [SCORE_W-1:0] pick_inc();
        case ($urandom_range(0, 5))
            0: return $urandom();
            1: return 32'hFFFF_FFFF;
            2: return SCORE_W'($urandom_range(0, 32'h0002_0000));
            default: return SCORE_W'($urandom_range(0, 32'h0000_4000));
        endcase
    endfunction

    // Mostly heap traffic with valid ids; some clears, decays of the top and noise
    task automatic random_phase(int items);
        int r;
        t_op op;
        for (int k = 0; k < items; k++) begin
            r = $urandom_range(0, 99);
            if (r < 25) op = OP_INSERT;
            else if (r < 55) op = OP_INCREASE;
            else if (r < 72) op = OP_REMOVE;
            else if (r < 92) op = OP_DECAY;
            else if (r < 95) op = OP_CLEAR;
            else op = t_op'($urandom_range(0, 7));
            if (op == OP_DECAY && $urandom_range(0, 1) == 0)
                send_cmd(op, o_top_elem, pick_inc());
            else
                send_cmd(op, pick_id(), pick_inc());
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = '0;
        start = 1'b0;
        i_op = OP_INSERT;
        i_elem = '0;
        i_increment = '0;
        cmd_cnt = 0;
        cur_n = 255;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: extremes, every op, bad ids, empty remove, nontop decay, overflow
        send_cmd(OP_INSERT, 8'd1, '0);
        send_cmd(OP_INSERT, 8'd0, '0);
        send_cmd(OP_INCREASE, 8'd255, 32'hFFFE_FFFF);
        send_cmd(OP_INCREASE, 8'd255, 32'h0000_0001);
        send_cmd(OP_INCREASE, 8'd7, 32'hFFFF_FFFF);
        send_cmd(OP_DECAY, 8'd3, '0);
        send_cmd(OP_DECAY, 8'd255, '0);
        send_cmd(OP_REMOVE, 8'd0, '0);
        send_cmd(OP_DECAY, 8'd1, '0);
        send_cmd(OP_CLEAR, 8'hFF, '0);
        send_cmd(t_op'(3'd5), 8'hAA, 32'h5555_5555);
        send_cmd(t_op'(3'd7), 8'h55, 32'hAAAA_AAAA);
        set_elems(8'd1);
        send_cmd(OP_INCREASE, 8'd2, 32'd1);
        send_cmd(OP_REMOVE, 8'd0, '0);
        send_cmd(OP_REMOVE, 8'd0, '0);
        send_cmd(OP_DECAY, 8'd1, '0);
        send_cmd(OP_INSERT, 8'd1, '0);
        send_cmd(OP_DECAY, 8'd1, '0);
        set_elems(8'd0);
        send_cmd(OP_INSERT, 8'd1, '0);
        send_cmd(OP_REMOVE, 8'd0, '0);

        // Random phases over several heap sizes, extremes included
        set_elems(8'd5);
        random_phase(400);
        set_elems(8'd255);
        random_phase(350);
        set_elems(8'd2);
        random_phase(250);
        set_elems(8'd17);
        random_phase(450);
        set_elems(8'($urandom_range(1, 255)));
        random_phase(450);

        start <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        $display("Ran %0d commands over heap sizes 0, 1, 2, 5, 17, 255 and one random size,",
                 cmd_cnt);
        $display("covering every op code, bad ids, overflow, empty removes and top decays.");
        if (fail_cnt == 0) $display("Verification passed");
        else $display("Verification failed");
        $finish;
    end

endmodule
